@@ sv/bounded_double_ended_queue_macros.svh @@
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bdq_pkg.sv @@
// Shared types and constants of the bounded deque.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int CAP_W         = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_PUSH_RIGHT = 2'd1,
    OP_POP_LEFT   = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Outcome of one operation as decided by the pointer control.
  typedef struct packed {
    status_t status;
    logic    from_ram;
  } bdq_res_t;

endpackage

@@ sv/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps
// Bounded deque on a single-port ring-buffer RAM. Each input transaction
// carries an operation in s_tuser (push left, push right, pop left, pop
// right) and a value in s_tdata; each one yields exactly one output
// transaction with a status in m_tuser (pushed, popped, full, empty) and the
// value pushed or popped in m_tdata, zero when the operation is refused.
// Pushes are refused once the entry count reaches min(capacity, DEPTH); a
// capacity of zero refuses every push, and lowering it below the current
// count keeps the entries. Throughput is one operation per cycle while the
// output is taken; the result appears in the cycle after acceptance. The
// single RAM port with registered read does at most one access per op. The
// output register holds a result under backpressure and s_tready drops
// only while it is full and not being taken. Write capacity only while idle.
module bounded_double_ended_queue import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]        s_tuser,   // [1:0] op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] item_value
  output logic [1:0]        m_tuser,   // [1:0] status
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata
);

  logic [CAP_W-1:0]         capacity;
  logic                     accept;
  logic                     mem_we, mem_re;
  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic [DATA_W-1:0]        ram_rdata;
  bdq_res_t                 res;

  // Output stage: status, pushed value and a select for the RAM read data.
  status_t                  out_status;
  logic [DATA_W-1:0]        out_value;
  logic                     out_from_ram;

  // Advance whenever the output slot is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  bdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op_t'(s_tuser)),
    .capacity (capacity),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .res      (res)
  );

  // The RAM read register only loads on a pop, so it holds while stalled.
  bdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (s_tdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload of the output stage; refused operations drop the value to zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status   <= res.status;
      out_from_ram <= res.from_ram;
      out_value    <= (res.status == ST_PUSHED) ? s_tdata : '0;
    end
  end

  assign m_tdata = out_from_ram ? ram_rdata : out_value;
  assign m_tuser = out_status;

endmodule

@@ sv/bdq_ram.sv @@
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ sv/bdq_ctrl.sv @@
// Pointer, count and capacity control of the deque ring buffer.
`timescale 1ns / 1ps
module bdq_ctrl import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  op_t                      op,
  input  logic [CAP_W-1:0]         capacity,
  output logic                     mem_we,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output bdq_res_t                 res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic [PW-1:0] front, front_next;
  logic [PW-1:0] back, back_next;
  logic [CW-1:0] count, count_next;

  logic [PW-1:0] front_prev, front_inc, back_prev, back_inc;
  logic [LW-1:0] cap_l, limit;
  logic          is_push, push_ok, pop_ok;

  always_comb begin
    front_prev = (front == '0) ? LAST : front - 1'b1;
    front_inc  = (front == LAST) ? '0 : front + 1'b1;
    back_prev  = (back == '0) ? LAST : back - 1'b1;
    back_inc   = (back == LAST) ? '0 : back + 1'b1;

    cap_l   = LW'(capacity);
    limit   = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
    is_push = op inside {OP_PUSH_LEFT, OP_PUSH_RIGHT};
    push_ok = is_push && (LW'(count) < limit);
    pop_ok  = !is_push && (count != '0);
  end

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    mem_addr   = front;
    case (op)
      OP_PUSH_LEFT: begin
        mem_addr = front_prev;
        if (push_ok) front_next = front_prev;
      end
      OP_PUSH_RIGHT: begin
        mem_addr = back;
        if (push_ok) back_next = back_inc;
      end
      OP_POP_LEFT: begin
        mem_addr = front;
        if (pop_ok) front_next = front_inc;
      end
      OP_POP_RIGHT: begin
        mem_addr = back_prev;
        if (pop_ok) back_next = back_prev;
      end
      default: begin
        mem_addr = front;
      end
    endcase
    if (push_ok) count_next = count + 1'b1;
    else if (pop_ok) count_next = count - 1'b1;
  end

  always_comb begin
    mem_we       = accept && push_ok;
    mem_re       = accept && pop_ok;
    res.from_ram = pop_ok;
    if (is_push) res.status = push_ok ? ST_PUSHED : ST_FULL;
    else res.status = pop_ok ? ST_POPPED : ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

endmodule

@@ sv/bdq_checker.sv @@
// Port-level checker for the bounded deque, bound to the top level.
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_macros.svh"
module bdq_checker import bdq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [DATA_W-1:0] s_tdata,
  input logic [1:0]        s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [1:0]        m_tuser
);

  `BDQ_ASSERT_NOW(a_refused_zero, m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY), m_tdata == '0, "refused result carries a nonzero value")
  `BDQ_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "accepted transaction gave no result in the next cycle")
  `BDQ_ASSERT_NEXT(a_push_result, s_tvalid && s_tready && !s_tuser[1], (m_tuser == ST_PUSHED && m_tdata == $past(s_tdata)) || m_tuser == ST_FULL, "push result does not match the pushed value")
  `BDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);
